// ===== rtl/apw_pkg.sv =====
// Shared types, widths and reset values for the wrapped-angle PID controller.
// Used by every module under rtl; depends on nothing else.
package apw_pkg;

    localparam int ANGLE_W   = 13;
    localparam int GAIN_W    = 32;
    localparam int LIMIT_W   = 15;
    localparam int SUM_W     = 16;
    localparam int DRIVE_W   = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_TDATA_W = 32;

    localparam int DEF_ANGLE_RANGE        = 8192;
    localparam int DEF_GAIN_FRACTION_BITS = 16;

    localparam logic signed [GAIN_W-1:0] RST_P_GAIN = GAIN_W'(4968);
    localparam logic signed [GAIN_W-1:0] RST_I_GAIN = GAIN_W'(0);
    localparam logic signed [GAIN_W-1:0] RST_D_GAIN = GAIN_W'(5177);
    localparam logic signed [GAIN_W-1:0] RST_F_GAIN = GAIN_W'(0);
    localparam logic [LIMIT_W-1:0]       RST_LIMIT  = LIMIT_W'(15000);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_P_GAIN    = 3'd0,
        CFG_I_GAIN    = 3'd1,
        CFG_D_GAIN    = 3'd2,
        CFG_F_GAIN    = 3'd3,
        CFG_INT_LIMIT = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic signed [GAIN_W-1:0] p;
        logic signed [GAIN_W-1:0] i;
        logic signed [GAIN_W-1:0] d;
        logic signed [GAIN_W-1:0] f;
    } t_gains;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Width of the wrapped error for a given circle size.
    function automatic int err_width(input int range);
        int half;
        half = range >> 1;
        if (half > (1 << ANGLE_W) - 1) begin
            return $clog2(half + 1) + 1;
        end
        return ANGLE_W + 1;
    endfunction

    function automatic int calc_width(input int range);
        return max_int(ANGLE_W + 2, $clog2(range) + 2);
    endfunction

    function automatic int prod_width(input int range);
        return GAIN_W + max_int(err_width(range) + 1, SUM_W);
    endfunction

    function automatic int acc_width(input int range);
        return prod_width(range) + 2;
    endfunction

endpackage

// ===== rtl/apw_error.sv =====
// Error path: angle wrap, first-sample seeding, clamped integral and differences.
// Holds the controller state; depends on apw_pkg.
module apw_error #(
    parameter int ANGLE_RANGE = apw_pkg::DEF_ANGLE_RANGE
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_load,
    input  logic                                          i_en,
    input  logic [apw_pkg::ANGLE_W-1:0]                   i_target,
    input  logic [apw_pkg::ANGLE_W-1:0]                   i_measured,
    input  logic [apw_pkg::LIMIT_W-1:0]                   i_limit,
    output logic signed [apw_pkg::err_width(ANGLE_RANGE)-1:0] o_error,
    output logic signed [apw_pkg::err_width(ANGLE_RANGE):0]   o_deriv,
    output logic signed [apw_pkg::SUM_W-1:0]              o_sum,
    output logic signed [apw_pkg::ANGLE_W:0]              o_ff
);

    localparam int ERR_W  = apw_pkg::err_width(ANGLE_RANGE);
    localparam int CALC_W = apw_pkg::calc_width(ANGLE_RANGE);
    localparam int SN_W   = apw_pkg::max_int(apw_pkg::SUM_W, ERR_W) + 1;
    localparam int AW     = apw_pkg::ANGLE_W;

    localparam logic signed [CALC_W-1:0] L_RANGE = CALC_W'(ANGLE_RANGE);
    localparam logic signed [CALC_W-1:0] L_HALF  = CALC_W'(ANGLE_RANGE / 2);

    logic                       r_first;
    logic signed [ERR_W-1:0]    r_prev_error;
    logic signed [apw_pkg::SUM_W-1:0] r_sum_state;
    logic [AW-1:0]              r_prev_target;

    logic signed [CALC_W-1:0]   n_diff;
    logic signed [CALC_W-1:0]   n_wrapped;
    logic signed [ERR_W-1:0]    n_error;
    logic signed [ERR_W-1:0]    n_prev_eff;
    logic signed [ERR_W:0]      n_deriv;
    logic signed [SN_W-1:0]     n_raw_sum;
    logic signed [SN_W-1:0]     n_lim;
    logic signed [SN_W-1:0]     n_clamped;
    logic signed [apw_pkg::SUM_W-1:0] n_sum;
    logic signed [AW:0]         n_ff;

    always_comb begin
        n_diff = $signed({{(CALC_W - AW){1'b0}}, i_target})
               - $signed({{(CALC_W - AW){1'b0}}, i_measured});
        priority if (n_diff > L_HALF) begin
            n_wrapped = n_diff - L_RANGE;
        end else if (n_diff < -L_HALF) begin
            n_wrapped = n_diff + L_RANGE;
        end else begin
            n_wrapped = n_diff;
        end
        n_error    = n_wrapped[ERR_W-1:0];
        n_prev_eff = r_first ? n_error : r_prev_error;
        n_deriv    = (ERR_W + 1)'(n_error) - (ERR_W + 1)'(n_prev_eff);

        n_raw_sum = SN_W'(r_sum_state) + SN_W'(n_error);
        n_lim     = $signed({{(SN_W - apw_pkg::LIMIT_W){1'b0}}, i_limit});
        priority if (n_raw_sum < -n_lim) begin
            n_clamped = -n_lim;
        end else if (n_raw_sum > n_lim) begin
            n_clamped = n_lim;
        end else begin
            n_clamped = n_raw_sum;
        end
        n_sum = n_clamped[apw_pkg::SUM_W-1:0];

        n_ff = $signed({1'b0, i_target}) - $signed({1'b0, r_prev_target});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first       <= 1'b1;
            r_prev_error  <= '0;
            r_sum_state   <= '0;
            r_prev_target <= '0;
        end else if (i_load) begin
            r_first       <= 1'b0;
            r_prev_error  <= n_error;
            r_sum_state   <= n_sum;
            r_prev_target <= i_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_error <= n_error;
            o_deriv <= n_deriv;
            o_sum   <= n_sum;
            o_ff    <= n_ff;
        end
    end

endmodule

// ===== rtl/apw_gain.sv =====
// Gain stage: four parallel registered products, then their registered sum.
// Depends on apw_pkg.
module apw_gain #(
    parameter int ANGLE_RANGE = apw_pkg::DEF_ANGLE_RANGE
) (
    input  logic                                              i_clk,
    input  apw_pkg::t_pipe_en                                 i_en,
    input  apw_pkg::t_gains                                   i_gains,
    input  logic signed [apw_pkg::err_width(ANGLE_RANGE)-1:0] i_error,
    input  logic signed [apw_pkg::err_width(ANGLE_RANGE):0]   i_deriv,
    input  logic signed [apw_pkg::SUM_W-1:0]                  i_sum,
    input  logic signed [apw_pkg::ANGLE_W:0]                  i_ff,
    output logic signed [apw_pkg::acc_width(ANGLE_RANGE)-1:0] o_acc
);

    localparam int ERR_W  = apw_pkg::err_width(ANGLE_RANGE);
    localparam int GW     = apw_pkg::GAIN_W;
    localparam int ACC_W  = apw_pkg::acc_width(ANGLE_RANGE);

    logic signed [GW+ERR_W-1:0]            n_prod_p;
    logic signed [GW+apw_pkg::SUM_W-1:0]   n_prod_i;
    logic signed [GW+ERR_W:0]              n_prod_d;
    logic signed [GW+apw_pkg::ANGLE_W:0]   n_prod_f;

    logic signed [GW+ERR_W-1:0]            r_prod_p;
    logic signed [GW+apw_pkg::SUM_W-1:0]   r_prod_i;
    logic signed [GW+ERR_W:0]              r_prod_d;
    logic signed [GW+apw_pkg::ANGLE_W:0]   r_prod_f;

    logic signed [ACC_W-1:0]               n_acc;

    assign n_prod_p = i_gains.p * i_error;
    assign n_prod_i = i_gains.i * i_sum;
    assign n_prod_d = i_gains.d * i_deriv;
    assign n_prod_f = i_gains.f * i_ff;

    assign n_acc = ACC_W'(r_prod_p) + ACC_W'(r_prod_i)
                 + ACC_W'(r_prod_d) + ACC_W'(r_prod_f);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
            r_prod_f <= n_prod_f;
        end
        if (i_en.s3) begin
            o_acc <= n_acc;
        end
    end

endmodule

// ===== rtl/apw_out.sv =====
// Output stage: fixed-point shift with truncation toward zero and 16-bit saturation.
// Depends on apw_pkg.
module apw_out #(
    parameter int ANGLE_RANGE        = apw_pkg::DEF_ANGLE_RANGE,
    parameter int GAIN_FRACTION_BITS = apw_pkg::DEF_GAIN_FRACTION_BITS
) (
    input  logic                                              i_clk,
    input  logic                                              i_en,
    input  logic signed [apw_pkg::acc_width(ANGLE_RANGE)-1:0] i_acc,
    output logic signed [apw_pkg::DRIVE_W-1:0]                o_drive,
    output logic                                              o_saturated
);

    localparam int ACC_W = apw_pkg::acc_width(ANGLE_RANGE);
    localparam int DW    = apw_pkg::DRIVE_W;

    localparam logic signed [ACC_W-1:0] L_BIAS = ACC_W'((64'd1 << GAIN_FRACTION_BITS) - 64'd1);
    localparam logic signed [ACC_W-1:0] L_MAX  = ACC_W'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] L_MIN  = -ACC_W'(64'd1 << (DW - 1));

    logic signed [ACC_W-1:0] n_adj;
    logic signed [ACC_W-1:0] n_quot;
    logic signed [DW-1:0]    n_drive;
    logic                    n_sat;

    always_comb begin
        // A negative sum is biased so that the arithmetic shift rounds toward zero.
        n_adj  = i_acc + (i_acc[ACC_W-1] ? L_BIAS : '0);
        n_quot = n_adj >>> GAIN_FRACTION_BITS;
        priority if (n_quot > L_MAX) begin
            n_drive = L_MAX[DW-1:0];
            n_sat   = 1'b1;
        end else if (n_quot < L_MIN) begin
            n_drive = L_MIN[DW-1:0];
            n_sat   = 1'b1;
        end else begin
            n_drive = n_quot[DW-1:0];
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_drive     <= n_drive;
            o_saturated <= n_sat;
        end
    end

endmodule

// ===== rtl/angle_pid_with_wrap.sv =====
// Angle PID controller with encoder wrap-around: top level with configuration
// registers and pipeline flow control; depends on apw_pkg, apw_error, apw_gain, apw_out.
//
// One angle sample beat is accepted per clock unless the output stalls, and its drive beat
// passes the error, product, sum and output registers in turn; the pace is set by the error
// stage, which updates the integral, the previous error and the previous target in the cycle
// a beat is accepted. Each pipeline stage holds its beat while the output is stalled and empty
// stages still take new beats. Gains are signed Q16.16 and should be written
// only while no beat is in flight.
module angle_pid_with_wrap #(
    parameter int ANGLE_RANGE        = apw_pkg::DEF_ANGLE_RANGE,
    parameter int GAIN_FRACTION_BITS = apw_pkg::DEF_GAIN_FRACTION_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // Fields from bit 0: target_angle[12:0], measured_angle[25:13], zero fill.
    input  logic [apw_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // Fields from bit 0: drive[15:0].
    output logic [apw_pkg::DRIVE_W-1:0]          o_m_axis_tdata,
    // Fields from bit 0: saturated.
    output logic                                 o_m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [apw_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [apw_pkg::GAIN_W-1:0]           i_cfg_data
);

    localparam int ERR_W = apw_pkg::err_width(ANGLE_RANGE);
    localparam int ACC_W = apw_pkg::acc_width(ANGLE_RANGE);
    localparam int AW    = apw_pkg::ANGLE_W;

    apw_pkg::t_gains                 r_gains;
    logic [apw_pkg::LIMIT_W-1:0]     r_limit;
    logic                            r_vld1;
    logic                            r_vld2;
    logic                            r_vld3;
    logic                            r_vld4;

    apw_pkg::t_pipe_en               n_en;
    logic                            n_accept;

    logic signed [ERR_W-1:0]         w_error;
    logic signed [ERR_W:0]           w_deriv;
    logic signed [apw_pkg::SUM_W-1:0] w_sum;
    logic signed [AW:0]              w_ff;
    logic signed [ACC_W-1:0]         w_acc;
    logic signed [apw_pkg::DRIVE_W-1:0] w_drive;

    assign n_en.s4 = !r_vld4 || i_m_axis_tready;
    assign n_en.s3 = !r_vld3 || n_en.s4;
    assign n_en.s2 = !r_vld2 || n_en.s3;
    assign n_en.s1 = !r_vld1 || n_en.s2;

    assign o_s_axis_tready = n_en.s1;
    assign n_accept        = i_s_axis_tvalid && n_en.s1;
    assign o_m_axis_tvalid = r_vld4;
    assign o_m_axis_tdata  = w_drive;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (n_en.s1) begin
                r_vld1 <= i_s_axis_tvalid;
            end
            if (n_en.s2) begin
                r_vld2 <= r_vld1;
            end
            if (n_en.s3) begin
                r_vld3 <= r_vld2;
            end
            if (n_en.s4) begin
                r_vld4 <= r_vld3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.p <= apw_pkg::RST_P_GAIN;
            r_gains.i <= apw_pkg::RST_I_GAIN;
            r_gains.d <= apw_pkg::RST_D_GAIN;
            r_gains.f <= apw_pkg::RST_F_GAIN;
            r_limit   <= apw_pkg::RST_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                apw_pkg::CFG_P_GAIN: begin
                    r_gains.p <= i_cfg_data;
                end
                apw_pkg::CFG_I_GAIN: begin
                    r_gains.i <= i_cfg_data;
                end
                apw_pkg::CFG_D_GAIN: begin
                    r_gains.d <= i_cfg_data;
                end
                apw_pkg::CFG_F_GAIN: begin
                    r_gains.f <= i_cfg_data;
                end
                apw_pkg::CFG_INT_LIMIT: begin
                    r_limit <= i_cfg_data[apw_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    apw_error #(
        .ANGLE_RANGE (ANGLE_RANGE)
    ) u_error (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (n_accept),
        .i_en       (n_en.s1),
        .i_target   (i_s_axis_tdata[AW-1:0]),
        .i_measured (i_s_axis_tdata[2*AW-1:AW]),
        .i_limit    (r_limit),
        .o_error    (w_error),
        .o_deriv    (w_deriv),
        .o_sum      (w_sum),
        .o_ff       (w_ff)
    );

    apw_gain #(
        .ANGLE_RANGE (ANGLE_RANGE)
    ) u_gain (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_gains (r_gains),
        .i_error (w_error),
        .i_deriv (w_deriv),
        .i_sum   (w_sum),
        .i_ff    (w_ff),
        .o_acc   (w_acc)
    );

    apw_out #(
        .ANGLE_RANGE        (ANGLE_RANGE),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_out (
        .i_clk       (i_clk),
        .i_en        (n_en.s4),
        .i_acc       (w_acc),
        .o_drive     (w_drive),
        .o_saturated (o_m_axis_tuser)
    );

endmodule

// ===== dv/tb_angle_pid_with_wrap.sv =====
// Self-checking testbench for the wrapped-angle PID controller angle_pid_with_wrap.
// It predicts every drive beat in a scoreboard class and compares the beats the block emits.
// Depends on apw_pkg and the RTL under rtl only.
`timescale 1ns / 1ps

module tb_angle_pid_with_wrap;

    localparam int ANGLE_RANGE = apw_pkg::DEF_ANGLE_RANGE;
    localparam int HALF_CIRCLE = ANGLE_RANGE / 2;
    localparam int FRAC_BITS   = apw_pkg::DEF_GAIN_FRACTION_BITS;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BEATS = 250;
    localparam int DRAIN_GAP   = 8;
    localparam logic [apw_pkg::GAIN_W-1:0] GAIN_MAX = 32'h7FFF_FFFF;
    localparam logic [apw_pkg::GAIN_W-1:0] GAIN_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [apw_pkg::DRIVE_W-1:0] drive;
        logic                               sat;
    } t_drive_beat;

    class t_drive_scoreboard;
        logic signed [apw_pkg::GAIN_W-1:0] kp, ki, kd, kf;
        logic [apw_pkg::LIMIT_W-1:0]       sum_limit;
        logic signed [apw_pkg::ANGLE_W:0]  last_err;
        logic signed [apw_pkg::SUM_W-1:0]  err_sum;
        logic [apw_pkg::ANGLE_W-1:0]       prev_tgt;
        bit                                first;
        t_drive_beat                       pending_drives[$];
        int                                mismatches;
        int                                checked;
        int                                clipped;

        function new();
            kp = apw_pkg::RST_P_GAIN;
            ki = apw_pkg::RST_I_GAIN;
            kd = apw_pkg::RST_D_GAIN;
            kf = apw_pkg::RST_F_GAIN;
            sum_limit = apw_pkg::RST_LIMIT;
            last_err = '0;
            err_sum = '0;
            prev_tgt = '0;
            first = 1'b1;
            mismatches = 0;
            checked = 0;
            clipped = 0;
        endfunction

        function void set_reg(apw_pkg::t_cfg_reg idx, logic [apw_pkg::GAIN_W-1:0] val);
            case (idx)
                apw_pkg::CFG_P_GAIN:    kp = val;
                apw_pkg::CFG_I_GAIN:    ki = val;
                apw_pkg::CFG_D_GAIN:    kd = val;
                apw_pkg::CFG_F_GAIN:    kf = val;
                apw_pkg::CFG_INT_LIMIT: sum_limit = val[apw_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [apw_pkg::ANGLE_W-1:0] target,
                                  logic [apw_pkg::ANGLE_W-1:0] measured);
            longint err, ff, sum, lim, deriv, acc, mag;
            t_drive_beat want;
            ff = longint'(target) - longint'(prev_tgt);
            prev_tgt = target;
            err = longint'(target) - longint'(measured);
            if (err > HALF_CIRCLE) begin
                err -= ANGLE_RANGE;
            end else if (err < -HALF_CIRCLE) begin
                err += ANGLE_RANGE;
            end
            if (first) begin
                last_err = (apw_pkg::ANGLE_W + 1)'(err);
                first = 1'b0;
            end
            lim = longint'(sum_limit);
            sum = longint'(err_sum) + err;
            if (sum < -lim) begin
                sum = -lim;
            end
            if (sum > lim) begin
                sum = lim;
            end
            err_sum = apw_pkg::SUM_W'(sum);
            deriv = err - longint'(last_err);
            last_err = (apw_pkg::ANGLE_W + 1)'(err);
            acc = longint'(kp) * err + longint'(ki) * sum + longint'(kd) * deriv
                + longint'(kf) * ff;
            mag = ((acc < 0) ? -acc : acc) >> FRAC_BITS;
            want.sat = 1'b0;
            if (acc < 0) begin
                if (mag > 32768) begin
                    want.drive = -16'sd32768;
                    want.sat = 1'b1;
                end else begin
                    want.drive = apw_pkg::DRIVE_W'(-mag);
                end
            end else begin
                if (mag > 32767) begin
                    want.drive = 16'sd32767;
                    want.sat = 1'b1;
                end else begin
                    want.drive = apw_pkg::DRIVE_W'(mag);
                end
            end
            pending_drives.push_back(want);
        endfunction

        function void check_drive(logic [apw_pkg::DRIVE_W-1:0] drive, logic sat);
            t_drive_beat want;
            checked++;
            if (pending_drives.size() == 0) begin
                $error("drive beat with nothing expected: drive %0d saturated %0b",
                       $signed(drive), sat);
                mismatches++;
                return;
            end
            want = pending_drives.pop_front();
            if (want.sat) begin
                clipped++;
            end
            if (drive !== want.drive) begin
                $error("drive: expected %0d, got %0d", want.drive, $signed(drive));
                mismatches++;
            end
            if (sat !== want.sat) begin
                $error("saturated: expected %0b, got %0b", want.sat, sat);
                mismatches++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [apw_pkg::IN_TDATA_W-1:0] i_s_axis_tdata;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [apw_pkg::DRIVE_W-1:0]    o_m_axis_tdata;
    logic                           o_m_axis_tuser;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [apw_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [apw_pkg::GAIN_W-1:0]     i_cfg_data;

    t_drive_scoreboard sb = new();

    bit tx_idle;
    bit rx_idle;
    int long_hold_len;
    int samples_sent;
    int settings_used;
    int quiet_cycles = 0;
    logic [apw_pkg::ANGLE_W-1:0] walk_target;
    logic [apw_pkg::ANGLE_W-1:0] walk_measured;

    angle_pid_with_wrap u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [apw_pkg::GAIN_W-1:0] modest_gain();
        return $urandom_range(0, 1 << 19) - (1 << 18);
    endfunction

    task automatic send_sample(logic [apw_pkg::ANGLE_W-1:0] target,
                               logic [apw_pkg::ANGLE_W-1:0] measured);
        if (tx_idle && $urandom_range(0, 2) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, measured, target};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_sample(target, measured);
        samples_sent++;
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_drives.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic set_gains(logic [apw_pkg::GAIN_W-1:0] p, logic [apw_pkg::GAIN_W-1:0] i,
                             logic [apw_pkg::GAIN_W-1:0] d, logic [apw_pkg::GAIN_W-1:0] f,
                             logic [apw_pkg::LIMIT_W-1:0] lim);
        apw_pkg::t_cfg_reg idx;
        logic [apw_pkg::GAIN_W-1:0] val;
        wait_idle();
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: begin idx = apw_pkg::CFG_P_GAIN;    val = p; end
                1: begin idx = apw_pkg::CFG_I_GAIN;    val = i; end
                2: begin idx = apw_pkg::CFG_D_GAIN;    val = d; end
                3: begin idx = apw_pkg::CFG_F_GAIN;    val = f; end
                default: begin idx = apw_pkg::CFG_INT_LIMIT; val = apw_pkg::GAIN_W'(lim); end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= idx;
            i_cfg_data  <= val;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_reg(idx, val);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            walk_target   = walk_target + apw_pkg::ANGLE_W'($urandom_range(0, 64) - 32);
            walk_measured = walk_target + apw_pkg::ANGLE_W'($urandom_range(0, 400) - 200);
        end else if (pick < 9) begin
            walk_target   = apw_pkg::ANGLE_W'($urandom_range(0, ANGLE_RANGE - 1));
            walk_measured = apw_pkg::ANGLE_W'($urandom_range(0, ANGLE_RANGE - 1));
        end else begin
            walk_target   = $urandom_range(0, 1) ? '1 : apw_pkg::ANGLE_W'(HALF_CIRCLE);
            walk_measured = $urandom_range(0, 1) ? '0 : apw_pkg::ANGLE_W'(HALF_CIRCLE - 1);
        end
        send_sample(walk_target, walk_measured);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_drive(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL angle_pid_with_wrap");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_len != 0 && !hold_taken) begin
                hold_taken = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (long_hold_len) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else if (!rx_idle || $urandom_range(0, 3) != 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                repeat (idle_len() - 1) @(posedge i_clk);
            end
        end
    end

    initial begin
        samples_sent    = 0;
        settings_used   = 0;
        long_hold_len   = 0;
        tx_idle         = 1'b0;
        rx_idle         = 1'b0;
        walk_target     = '0;
        walk_measured   = '0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_addr      <= '0;
        i_cfg_data      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gains: first sample, both half-circle boundaries, wraps and integral clamp.
        send_sample(13'd0, 13'd0);
        send_sample(13'd4096, 13'd0);
        send_sample(13'd0, 13'd4096);
        send_sample(13'd4097, 13'd0);
        send_sample(13'd0, 13'd4097);
        send_sample(13'd8191, 13'd0);
        send_sample(13'd0, 13'd8191);
        send_sample(13'd8191, 13'd8191);
        repeat (5) send_sample(13'd4096, 13'd0);
        repeat (5) send_sample(13'd0, 13'd4096);

        // Extreme gains drive the output into both rails.
        set_gains(GAIN_MAX, GAIN_MIN, GAIN_MAX, GAIN_MIN, 15'h7FFF);
        send_sample(13'd4096, 13'd0);
        send_sample(13'd0, 13'd4096);
        send_sample(13'd0, 13'd0);
        send_sample(13'd8191, 13'd8191);
        send_sample(13'd1, 13'd0);
        send_sample(13'd0, 13'd1);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_gains(modest_gain(), modest_gain(), modest_gain(), modest_gain(),
                             apw_pkg::LIMIT_W'($urandom_range(0, 32767)));
                1: set_gains('0, modest_gain(), '0, '0, '0);
                2: set_gains(GAIN_MAX, GAIN_MIN, GAIN_MAX, GAIN_MIN, 15'h7FFF);
                3: set_gains(GAIN_MIN, GAIN_MAX, GAIN_MIN, GAIN_MAX,
                             apw_pkg::LIMIT_W'($urandom_range(0, 100)));
                4: set_gains($urandom, $urandom, $urandom, $urandom,
                             apw_pkg::LIMIT_W'($urandom_range(0, 32767)));
                default: set_gains(modest_gain(), modest_gain(), modest_gain(), modest_gain(),
                                   15'h7FFF);
            endcase
            tx_idle = (ph != 0);
            rx_idle = (ph != 0 && ph != 3);
            if (ph == 5) begin
                long_hold_len = 300;
            end
            repeat (PHASE_BEATS) send_random_sample();
        end

        wait_idle();
        $display("Sent %0d angle samples over %0d gain settings, including both rail extremes.",
                 samples_sent, settings_used);
        $display("Checked %0d drive beats, %0d of them clipped.", sb.checked, sb.clipped);
        if (sb.mismatches == 0 && sb.pending_drives.size() == 0) begin
            $display("PASS angle_pid_with_wrap");
        end else begin
            $display("FAIL angle_pid_with_wrap");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/apw_pkg.sv
rtl/apw_error.sv
rtl/apw_gain.sv
rtl/apw_out.sv
rtl/angle_pid_with_wrap.sv
dv/tb_angle_pid_with_wrap.sv
